// ===== sv/assert_macros.svh =====
// assertion macros used by the priority queue core
// no dependencies; compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rstn, prop)
`define ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== sv/pqrid_pkg.sv =====
// shared types and constants of the priority queue with removal by id
// no dependencies
`default_nettype none
package pqrid_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ModeW       = 2;
  localparam int unsigned IdW         = 16;
  localparam int unsigned PrioW       = 8;
  localparam int unsigned StatusW     = 2;

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LIST   = 2'd1,
    MODE_POP    = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WRITE,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/pqrid_cmd_if.sv =====
// command channel: valid/ready handshake with mode, id and priority
// depends on pqrid_pkg
`default_nettype none
interface pqrid_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [pqrid_pkg::ModeW-1:0] mode;
  logic [pqrid_pkg::IdW-1:0]   task_id;
  logic [pqrid_pkg::PrioW-1:0] priority_req;

  modport source (output valid, mode, task_id, priority_req, input ready);
  modport sink   (input valid, mode, task_id, priority_req, output ready);
endinterface
`default_nettype wire

// ===== sv/pqrid_res_if.sv =====
// result channel: valid/ready handshake with status, entry and last marker
// depends on pqrid_pkg
`default_nettype none
interface pqrid_res_if;
  logic                          valid;
  logic                          ready;
  logic [pqrid_pkg::StatusW-1:0] status;
  logic [pqrid_pkg::IdW-1:0]     task_id_res;
  logic [pqrid_pkg::PrioW-1:0]   priority_res;
  logic                          last;

  modport source (output valid, status, task_id_res, priority_res, last, input ready);
  modport sink   (input valid, status, task_id_res, priority_res, last, output ready);
endinterface
`default_nettype wire

// ===== sv/pqrid_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none
module pqrid_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/priority_queue_remove_by_id_core.sv =====
// sorted priority queue with removal by id, entries held in one ram
// depends on pqrid_pkg, pqrid_cmd_if, pqrid_res_if, pqrid_ram, assert_macros.svh
// sequence: insert walks from the tail, then writes; list returns each entry;
//   pop and remove walk every stored entry; full or empty replies skip the walk
// one request at a time, set by the single ram read port that the sequencer walks
//   entry by entry (read, then evaluate)
// reset: asynchronous active low, clears count and control; ram not cleared
`default_nettype none
`include "assert_macros.svh"
module priority_queue_remove_by_id_core #(
  parameter int unsigned Capacity = pqrid_pkg::DefCapacity
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pqrid_cmd_if.sink   cmd_i,
  pqrid_res_if.source res_o
);
  import pqrid_pkg::*;

  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned AddrW = $clog2(Capacity);

  // sequencer and request registers
  state_e           state_q, state_d;
  mode_e            op_q, op_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [PrioW-1:0] prio_q, prio_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             shift_q, shift_d;
  status_e          status_q, status_d;
  entry_t           hit_q, hit_d;

  // output register
  logic             res_valid_q, res_valid_d;
  status_e          res_status_q, res_status_d;
  logic [IdW-1:0]   res_id_q, res_id_d;
  logic [PrioW-1:0] res_prio_q, res_prio_d;
  logic             res_last_q, res_last_d;

  // ram port signals
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;

  // shared evaluation terms
  entry_t          rd_entry;
  logic            cmd_fire;
  logic            out_free;
  logic            is_last;
  logic            idx_is_one;
  logic            prio_ge;
  logic            id_match;
  logic [CntW-1:0] idx_m1;
  logic [CntW-1:0] idx_p1;

  assign rd_entry   = entry_t'(ram_rdata);
  assign cmd_fire   = cmd_i.valid && cmd_i.ready;
  assign out_free   = !res_valid_q || res_o.ready;
  assign idx_m1     = idx_q - CntW'(1);
  assign idx_p1     = idx_q + CntW'(1);
  assign is_last    = (idx_p1 == count_q);
  assign idx_is_one = (idx_q == CntW'(1));
  assign prio_ge    = (rd_entry.prio >= prio_q);
  // pop always takes the head, remove takes the first id match
  assign id_match   = (op_q == MODE_POP) || (rd_entry.id == id_q);

  // insert walks from the tail downwards, everything else from the head
  assign ram_raddr = (op_q == MODE_INSERT) ? idx_m1[AddrW-1:0] : idx_q[AddrW-1:0];

  pqrid_ram #(
    .Width($bits(entry_t)),
    .Depth(Capacity)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          if (mode_e'(cmd_i.mode) == MODE_INSERT) begin
            if (count_q == CntW'(Capacity)) begin
              state_d = ST_RESP;
            end else if (count_q == '0) begin
              state_d = ST_WRITE;
            end else begin
              state_d = ST_READ;
            end
          end else if (count_q == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        case (op_q)
          MODE_INSERT: begin
            if (prio_ge || idx_is_one) begin
              state_d = ST_WRITE;
            end else begin
              state_d = ST_READ;
            end
          end
          MODE_LIST: begin
            if (out_free) begin
              state_d = is_last ? ST_IDLE : ST_READ;
            end
          end
          default: state_d = is_last ? ST_RESP : ST_READ;
        endcase
      end
      ST_WRITE: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs of the sequencer
  always_comb begin
    op_d         = op_q;
    id_d         = id_q;
    prio_d       = prio_q;
    idx_d        = idx_q;
    count_d      = count_q;
    shift_d      = shift_q;
    status_d     = status_q;
    hit_d        = hit_q;
    res_valid_d  = res_valid_q && !res_o.ready;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_prio_d   = res_prio_q;
    res_last_d   = res_last_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AddrW-1:0];
    ram_wdata    = '{id: id_q, prio: prio_q};

    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          op_d     = mode_e'(cmd_i.mode);
          id_d     = cmd_i.task_id;
          prio_d   = cmd_i.priority_req;
          shift_d  = 1'b0;
          hit_d    = '0;
          status_d = STAT_OK;
          if (mode_e'(cmd_i.mode) == MODE_INSERT) begin
            idx_d = count_q;
            if (count_q == CntW'(Capacity)) begin
              status_d = STAT_FULL;
            end
          end else begin
            idx_d = '0;
            if (count_q == '0) begin
              status_d = STAT_EMPTY;
            end
          end
        end
      end
      ST_EVAL: begin
        case (op_q)
          MODE_INSERT: begin
            // move a lower priority entry one place toward the tail
            if (!prio_ge) begin
              ram_we    = 1'b1;
              ram_wdata = rd_entry;
              idx_d     = idx_m1;
            end
          end
          MODE_LIST: begin
            if (out_free) begin
              res_valid_d  = 1'b1;
              res_status_d = STAT_OK;
              res_id_d     = rd_entry.id;
              res_prio_d   = rd_entry.prio;
              res_last_d   = is_last;
              idx_d        = idx_p1;
            end
          end
          default: begin
            // search until a hit, then close the gap one entry a step
            if (shift_q) begin
              ram_we    = 1'b1;
              ram_waddr = idx_m1[AddrW-1:0];
              ram_wdata = rd_entry;
            end else if (id_match) begin
              hit_d   = rd_entry;
              shift_d = 1'b1;
            end
            idx_d = idx_p1;
            if (is_last) begin
              if (shift_q || id_match) begin
                count_d = count_q - CntW'(1);
              end else begin
                status_d = STAT_NOTFOUND;
              end
            end
          end
        endcase
      end
      ST_WRITE: begin
        ram_we  = 1'b1;
        count_d = count_q + CntW'(1);
      end
      ST_RESP: begin
        if (out_free) begin
          res_valid_d  = 1'b1;
          res_status_d = status_q;
          res_id_d     = hit_q.id;
          res_prio_d   = hit_q.prio;
          res_last_d   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      shift_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      shift_q     <= shift_d;
      res_valid_q <= res_valid_d;
    end
  end

  // request and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    prio_q       <= prio_d;
    idx_q        <= idx_d;
    status_q     <= status_d;
    hit_q        <= hit_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_prio_q   <= res_prio_d;
    res_last_q   <= res_last_d;
  end

  assign cmd_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = res_valid_q;
  assign res_o.status       = res_status_q;
  assign res_o.task_id_res  = res_id_q;
  assign res_o.priority_res = res_prio_q;
  assign res_o.last         = res_last_q;

  // fill level never goes past the store size
  `ASSERT_RST(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Capacity))
  // the fill level moves by at most one entry per cycle
  `ASSERT_RST(a_count_step, clk_i, rst_ni, count_q - $past(count_q) + CntW'(1) <= CntW'(2))
  // an accepted request always starts the sequencer
  `ASSERT_RST(a_busy_after_req, clk_i, rst_ni, cmd_fire |=> state_q != ST_IDLE)
  // the store is only written while a request is being worked on
  `ASSERT_RST(a_write_busy, clk_i, rst_ni, ram_we |-> state_q != ST_IDLE)

endmodule
`default_nettype wire
